/* design/tccs_pkg.sv */
`default_nettype none

package tccs_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // Widths of the cursor, the store address and the item fields.
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Character codes with special meaning.
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'd32;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the input item
        logic cnt_clear;  // restart the fill counter
        logic fill;       // blank the cell at base plus counter, advance counter
        logic base_adv;   // move the top-row offset down one row
        logic col_zero;
        logic col_dec;
        logic col_inc;
        logic row_inc;
        logic lin_load;   // form the logical cell index
        logic phys;       // map logical index to store address
        logic store;      // write the item's cell at the store address
        logic mem_read;   // read the store address
        logic emit;       // present the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic is_newline;
        logic is_backspace;
        logic col_is_zero;
        logic col_is_full;
        logic row_is_last;
        logic cnt_row_end;
        logic cnt_all_end;
    } t_dp_status;

endpackage

`default_nettype wire

/* design/tccs_ctrl.sv */
`default_nettype none

module tccs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire tccs_pkg::t_dp_status i_status,
    output tccs_pkg::t_dp_cmd         o_cmd,
    output logic                      o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCROLL,
        S_ADDR,
        S_PHYS,
        S_READ,
        S_WRITE,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_then_write, n_then_write;

    // Next state and datapath commands.
    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_then_write = r_then_write;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.fill = 1'b1;
                if (i_status.cnt_all_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.kind == tccs_pkg::KIND_READ) begin
                    n_state = S_ADDR;
                end else if (i_status.is_newline) begin
                    o_cmd.col_zero = 1'b1;
                    if (i_status.row_is_last) begin
                        o_cmd.cnt_clear = 1'b1;
                        n_then_write    = 1'b0;
                        n_state         = S_SCROLL;
                    end else begin
                        o_cmd.row_inc = 1'b1;
                        n_state       = S_FINISH;
                    end
                end else if (i_status.is_backspace) begin
                    if (i_status.col_is_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.col_dec = 1'b1;
                        n_state       = S_ADDR;
                    end
                end else if (i_status.col_is_full) begin
                    o_cmd.col_zero = 1'b1;
                    if (i_status.row_is_last) begin
                        o_cmd.cnt_clear = 1'b1;
                        n_then_write    = 1'b1;
                        n_state         = S_SCROLL;
                    end else begin
                        o_cmd.row_inc = 1'b1;
                        n_state       = S_ADDR;
                    end
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_SCROLL: begin
                o_cmd.fill = 1'b1;
                if (i_status.cnt_row_end) begin
                    o_cmd.base_adv = 1'b1;
                    n_state        = r_then_write ? S_ADDR : S_FINISH;
                end
            end
            S_ADDR: begin
                o_cmd.lin_load = 1'b1;
                n_state        = S_PHYS;
            end
            S_PHYS: begin
                o_cmd.phys = 1'b1;
                n_state    = (i_status.kind == tccs_pkg::KIND_READ) ? S_READ : S_WRITE;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_FINISH;
            end
            S_WRITE: begin
                o_cmd.store   = 1'b1;
                o_cmd.col_inc = !i_status.is_backspace;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // State and registered outputs; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_busy       <= 1'b1;
            r_then_write <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy       <= n_busy;
            r_then_write <= n_then_write;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

/* design/tccs_datapath.sv */
`default_nettype none

module tccs_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tccs_pkg::t_dp_cmd                i_cmd,
    input  wire logic                             i_kind,
    input  wire logic [tccs_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic [tccs_pkg::ATTR_W-1:0]      i_color,
    input  wire logic [tccs_pkg::IDX_W-1:0]       i_cell_index,
    output tccs_pkg::t_dp_status                  o_status,
    output logic                                  o_strobe,
    output logic [tccs_pkg::CHAR_W-1:0]           o_cell_char,
    output logic [tccs_pkg::ATTR_W-1:0]           o_cell_color,
    output logic [tccs_pkg::COL_W-1:0]            o_cursor_column,
    output logic [tccs_pkg::ROW_W-1:0]            o_cursor_row
);

    localparam logic [tccs_pkg::CELL_W-1:0] BLANK_CELL =
        {{tccs_pkg::ATTR_W{1'b0}}, tccs_pkg::CODE_SPACE};

    // Screen store; physical rows rotate so a scroll only clears one row.
    logic [tccs_pkg::CELL_W-1:0] mem [tccs_pkg::CELL_COUNT];

    // Latched item.
    logic                          r_kind;
    logic [tccs_pkg::CHAR_W-1:0]   r_char;
    logic [tccs_pkg::ATTR_W-1:0]   r_color;
    logic [tccs_pkg::IDX_W-1:0]    r_idx;

    // Cursor, top-row offset and fill counter.
    logic [tccs_pkg::COL_W-1:0]    r_col;
    logic [tccs_pkg::ROW_W-1:0]    r_row;
    logic [tccs_pkg::ADDR_W-1:0]   r_base;
    logic [tccs_pkg::ADDR_W-1:0]   r_cnt;

    // Address path and read data.
    logic [tccs_pkg::IDX_W-1:0]    r_lin;
    logic                          r_in_range;
    logic [tccs_pkg::ADDR_W-1:0]   r_phys;
    logic [tccs_pkg::CELL_W-1:0]   r_rdata;
    logic                          r_strobe;

    logic [tccs_pkg::IDX_W:0]      phys_sum;
    logic [tccs_pkg::IDX_W:0]      phys_wrap;
    logic [tccs_pkg::ADDR_W:0]     base_sum;
    logic [tccs_pkg::ADDR_W-1:0]   fill_addr;
    logic [tccs_pkg::CELL_W-1:0]   store_cell;
    logic                          is_backspace;

    assign is_backspace = (r_char == tccs_pkg::CODE_BACKSPACE);

    // Logical index plus top-row offset, folded back into the store once.
    always_comb begin
        phys_sum  = {1'b0, r_lin} + (tccs_pkg::IDX_W + 1)'(r_base);
        phys_wrap = (phys_sum >= (tccs_pkg::IDX_W + 1)'(tccs_pkg::CELL_COUNT))
                  ? phys_sum - (tccs_pkg::IDX_W + 1)'(tccs_pkg::CELL_COUNT)
                  : phys_sum;
        base_sum  = {1'b0, r_base} + (tccs_pkg::ADDR_W + 1)'(tccs_pkg::COLUMNS);
    end

    // The top row always starts on a row boundary, so this never wraps.
    assign fill_addr  = r_base + r_cnt;
    assign store_cell = is_backspace ? {r_color, tccs_pkg::CODE_SPACE} : {r_color, r_char};

    // Status for the controller.
    always_comb begin
        o_status.kind         = r_kind;
        o_status.is_newline   = (r_char == tccs_pkg::CODE_NEWLINE);
        o_status.is_backspace = is_backspace;
        o_status.col_is_zero  = (r_col == '0);
        o_status.col_is_full  = (r_col == tccs_pkg::COL_W'(tccs_pkg::COLUMNS));
        o_status.row_is_last  = (r_row == tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1));
        o_status.cnt_row_end  = (r_cnt == tccs_pkg::ADDR_W'(tccs_pkg::COLUMNS - 1));
        o_status.cnt_all_end  = (r_cnt == tccs_pkg::ADDR_W'(tccs_pkg::CELL_COUNT - 1));
    end

    // Item capture and address path.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_char  <= i_char_code;
            r_color <= i_color;
            r_idx   <= i_cell_index;
        end
        if (i_cmd.lin_load) begin
            if (r_kind == tccs_pkg::KIND_READ) begin
                r_lin      <= r_idx;
                r_in_range <= (r_idx < tccs_pkg::IDX_W'(tccs_pkg::CELL_COUNT));
            end else begin
                r_lin      <= tccs_pkg::IDX_W'(r_row * tccs_pkg::COLUMNS)
                            + tccs_pkg::IDX_W'(r_col);
                r_in_range <= 1'b1;
            end
        end
        if (i_cmd.phys) begin
            r_phys <= r_in_range ? phys_wrap[tccs_pkg::ADDR_W-1:0] : '0;
        end
    end

    // Cursor, offset, counter and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col           <= '0;
            r_row           <= '0;
            r_base          <= '0;
            r_cnt           <= '0;
            r_strobe        <= 1'b0;
            o_cell_char     <= '0;
            o_cell_color    <= '0;
            o_cursor_column <= '0;
            o_cursor_row    <= '0;
        end else begin
            if (i_cmd.col_zero) begin
                r_col <= '0;
            end else if (i_cmd.col_dec) begin
                r_col <= r_col - 1'b1;
            end else if (i_cmd.col_inc) begin
                r_col <= r_col + 1'b1;
            end
            if (i_cmd.row_inc) begin
                r_row <= r_row + 1'b1;
            end
            if (i_cmd.base_adv) begin
                r_base <= (base_sum >= (tccs_pkg::ADDR_W + 1)'(tccs_pkg::CELL_COUNT))
                        ? '0 : base_sum[tccs_pkg::ADDR_W-1:0];
            end
            if (i_cmd.cnt_clear) begin
                r_cnt <= '0;
            end else if (i_cmd.fill) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_strobe <= i_cmd.emit;
            if (i_cmd.emit) begin
                if (r_kind == tccs_pkg::KIND_READ && r_in_range) begin
                    o_cell_char  <= r_rdata[tccs_pkg::CHAR_W-1:0];
                    o_cell_color <= r_rdata[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
                end else begin
                    o_cell_char  <= '0;
                    o_cell_color <= '0;
                end
                o_cursor_column <= r_col;
                o_cursor_row    <= r_row;
            end
        end
    end

    // Store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            mem[fill_addr] <= BLANK_CELL;
        end else if (i_cmd.store) begin
            mem[r_phys] <= store_cell;
        end
        if (i_cmd.mem_read) begin
            r_rdata <= mem[r_phys];
        end
    end

    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

/* design/text_console_cursor_scroll.sv */
// A read, a stored character or a backspace goes through decode, the address and
// physical-address steps and a store access before the strobe; a newline, or a backspace
// at column zero, goes from decode to the strobe; a newline or wrap on the last row adds
// a pass that blanks one row. One transaction at a time: a new one is taken only once busy
// drops. The receiver cannot stall.
// Reset: synchronous, active low; cursor to row 0, column 0; busy clearing every cell.
`default_nettype none

module text_console_cursor_scroll (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_kind,
    input  wire logic [tccs_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic [tccs_pkg::ATTR_W-1:0]  i_color,
    input  wire logic [tccs_pkg::IDX_W-1:0]   i_cell_index,
    output logic                              o_strobe,
    output logic [tccs_pkg::CHAR_W-1:0]       o_cell_char,
    output logic [tccs_pkg::ATTR_W-1:0]       o_cell_color,
    output logic [tccs_pkg::COL_W-1:0]        o_cursor_column,
    output logic [tccs_pkg::ROW_W-1:0]        o_cursor_row
);

    tccs_pkg::t_dp_cmd    dp_cmd;
    tccs_pkg::t_dp_status dp_status;

    // Sequencer for each transaction, the clearing pass and scrolls.
    tccs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // Cursor, store and result registers.
    tccs_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_color         (i_color),
        .i_cell_index    (i_cell_index),
        .o_status        (dp_status),
        .o_strobe        (o_strobe),
        .o_cell_char     (o_cell_char),
        .o_cell_color    (o_cell_color),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row)
    );

    // An accepted transaction keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // Results are single-cycle strobes, never two in a row.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe lasted more than one cycle");

    // A result only follows a cycle in which the block was busy.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a transaction in progress");

    // The reported row stays on the screen; the column may reach COLUMNS, one past the last.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_cursor_row <= tccs_pkg::ROW_W'(tccs_pkg::ROWS - 1)
                      && o_cursor_column <= tccs_pkg::COL_W'(tccs_pkg::COLUMNS)))
        else $error("cursor out of range");

endmodule

`default_nettype wire
